// File: design/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared types, widths and helpers for the vector normalise block.
// ----------------------------------------------------------------------------
`default_nettype none

package vnorm_pkg;

  localparam int NCOMP         = 4;
  localparam int COMP_W        = 32;
  localparam int DIMS_W        = 3;
  localparam int MAX_DIM_DEF   = 4;
  localparam int FRAC_BITS_DEF = 16;

  // sum of up to four squares of 2^31 needs 65 bits, rounded up to whole pairs
  localparam int PROD_W  = 2 * COMP_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int NPAIR   = SUM_W / 2;
  localparam int ROOT_W  = NPAIR;
  localparam int IDX_W   = $clog2(NCOMP);

  typedef struct packed {
    logic        [DIMS_W-1:0] dims;
    logic signed [COMP_W-1:0] comp0;
    logic signed [COMP_W-1:0] comp1;
    logic signed [COMP_W-1:0] comp2;
    logic signed [COMP_W-1:0] comp3;
  } in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] unit0;
    logic signed [COMP_W-1:0] unit1;
    logic signed [COMP_W-1:0] unit2;
    logic signed [COMP_W-1:0] unit3;
    logic                     zero_length;
  } out_t;

  // magnitude of a two's complement component, most negative value gives 2^31
  function automatic logic [COMP_W-1:0] mag_of(input logic [COMP_W-1:0] v);
    logic [COMP_W-1:0] m;
    m = v[COMP_W-1] ? (~v + COMP_W'(1)) : v;
    return m;
  endfunction

endpackage

`default_nettype wire

// File: design/vnorm_sumsq.sv
// ----------------------------------------------------------------------------
// vnorm_sumsq
// Squares one component magnitude per cycle and accumulates the exact sum.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_sumsq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear,
  input  wire logic                       mag_vld,
  input  wire logic [vnorm_pkg::COMP_W-1:0] mag,
  output logic      [vnorm_pkg::SUM_W-1:0]  sum
);
  import vnorm_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic              prod_vld_r;
  logic [SUM_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= mag_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_vld) begin
      prod_r <= PROD_W'(mag) * PROD_W'(mag);
    end
    if (clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
  end

  assign sum = acc_r;

endmodule

`default_nettype wire

// File: design/vnorm_sqrt.sv
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Restoring integer square root, one radix-4 digit of the sum per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [vnorm_pkg::SUM_W-1:0] sum,
  output logic      [vnorm_pkg::ROOT_W-1:0] root,
  output logic                             done
);
  import vnorm_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(NPAIR + 1);

  logic [SUM_W-1:0]  sh_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_t;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign rem_t = {rem_r[REM_W-3:0], sh_r[SUM_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign fits  = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NPAIR);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh_r   <= sum;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      sh_r   <= {sh_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_t - trial) : rem_t;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign root = root_r;
  assign done = done_r;

  // remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r <= REM_W'({root_r, 1'b0})))
    else $error("sqrt remainder above bound");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !busy_r)
    else $error("sqrt started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("sqrt done longer than one cycle");

endmodule

`default_nettype wire

// File: design/vnorm_div.sv
// ----------------------------------------------------------------------------
// vnorm_div
// Restoring divider of magnitude * 2^FRAC_BITS by the length, one quotient
// bit per cycle; needs magnitude <= length.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_div #(
  parameter int FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [vnorm_pkg::COMP_W-1:0] mag,
  input  wire logic [vnorm_pkg::ROOT_W-1:0] den,
  output logic      [FRAC_BITS:0]           quo,
  output logic                              done
);
  import vnorm_pkg::*;

  localparam int REM_W = ROOT_W + 1;
  localparam int NSTEP = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NSTEP + 1);

  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] den_r;
  logic [FRAC_BITS:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              first_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_t;
  logic              ge;

  // first step compares the magnitude itself, later steps shift in zeros
  assign rem_t = first_r ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign ge    = (rem_t >= REM_W'(den_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NSTEP);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r   <= REM_W'(mag);
      den_r   <= den;
      q_r     <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= ge ? (rem_t - REM_W'(den_r)) : rem_t;
      q_r     <= {q_r[FRAC_BITS-1:0], ge};
      first_r <= 1'b0;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !first_r) |-> (rem_r < REM_W'(den_r)))
    else $error("divider remainder not below divisor");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !busy_r)
    else $error("divider started while busy");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (q_r[FRAC_BITS] == 1'b0 || q_r[FRAC_BITS-1:0] == '0))
    else $error("quotient above one");

endmodule

`default_nettype wire

// File: design/vector_normalise.sv
// Sequence: sum of squares, square root, then one divide per used component; a
//   zero-length vector skips the divides.
// Throughput: one item at a time (in_stall is high until the sequencer is idle),
//   set by the square root unit (33 steps) and the shared divider (FRAC_BITS + 1
//   steps per component); the next item is taken while a result waits.
// Reset: synchronous active-low rst_n idles the sequencer and drops out_valid.
// ----------------------------------------------------------------------------
// vector_normalise
// Euclidean normalisation of a vector of up to four Q16.16 components.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalise #(
  parameter int MAX_DIM   = vnorm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire vnorm_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output vnorm_pkg::out_t     out_data
);
  import vnorm_pkg::*;

  localparam int LIM = (MAX_DIM < NCOMP) ? MAX_DIM : NCOMP;
  localparam logic [DIMS_W-1:0] LIM_C = DIMS_W'(LIM);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_ROOT = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [COMP_W-1:0] comp_r [NCOMP];
  logic [COMP_W-1:0] unit_r [NCOMP];
  logic [DIMS_W-1:0] used_r;
  logic [DIMS_W-1:0] used_nxt;
  logic [DIMS_W-1:0] sq_cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic              len_zero_r;
  logic              root_go_r;
  logic              div_go_r;
  logic              out_valid_r;
  out_t              out_data_r;
  out_t              out_nxt;

  logic              in_acc;
  logic              out_free;
  logic              sq_vld;
  logic              sq_last;
  logic              div_last;
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] root;
  logic              root_done;
  logic [FRAC_BITS:0] quo;
  logic              div_done;
  logic [COMP_W-1:0] q_ext;
  logic [COMP_W-1:0] lane [NCOMP];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign used_nxt = (in_data.dims > LIM_C) ? LIM_C : in_data.dims;
  assign sq_vld   = (state_r == S_SQ) && (sq_cnt_r < used_r);
  assign sq_last  = (state_r == S_SQ) && (sq_cnt_r == used_r);
  assign div_last = (DIMS_W'(idx_r) + DIMS_W'(1) == used_r);

  vnorm_sumsq u_sumsq (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (in_acc),
    .mag_vld (sq_vld),
    .mag     (mag_of(comp_r[sq_cnt_r[IDX_W-1:0]])),
    .sum     (sum)
  );

  vnorm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (root_go_r),
    .sum   (sum),
    .root  (root),
    .done  (root_done)
  );

  vnorm_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .mag   (mag_of(comp_r[idx_r])),
    .den   (root),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SQ;
      S_SQ:   if (sq_last) state_nxt = S_ROOT;
      S_ROOT: begin
        if (root_done) state_nxt = (root == '0) ? S_OUT : S_DIV;
      end
      S_DIV:  if (div_done && div_last) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      root_go_r   <= 1'b0;
      div_go_r    <= 1'b0;
      sq_cnt_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      root_go_r <= sq_last;
      div_go_r  <= ((state_r == S_ROOT) && root_done && (root != '0)) ||
                   ((state_r == S_DIV) && div_done && !div_last);
      sq_cnt_r  <= (state_r == S_SQ) ? (sq_cnt_r + DIMS_W'(1)) : '0;
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // zero-extend the quotient; the component sign is applied when it is stored
  assign q_ext = COMP_W'(quo);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      comp_r[0] <= in_data.comp0;
      comp_r[1] <= in_data.comp1;
      comp_r[2] <= in_data.comp2;
      comp_r[3] <= in_data.comp3;
      used_r    <= used_nxt;
    end
    if ((state_r == S_ROOT) && root_done) begin
      len_zero_r <= (root == '0);
      idx_r      <= '0;
    end
    if ((state_r == S_DIV) && div_done) begin
      unit_r[idx_r] <= comp_r[idx_r][COMP_W-1] ? (COMP_W'(0) - q_ext) : q_ext;
      idx_r         <= idx_r + IDX_W'(1);
    end
    if ((state_r == S_OUT) && out_free) begin
      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      if (DIMS_W'(i) < used_r) begin
        lane[i] = len_zero_r ? comp_r[i] : unit_r[i];
      end else begin
        lane[i] = '0;
      end
    end
    out_nxt.unit0       = lane[0];
    out_nxt.unit1       = lane[1];
    out_nxt.unit2       = lane[2];
    out_nxt.unit3       = lane[3];
    out_nxt.zero_length = len_zero_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SQ))
    else $error("transfer did not start the sum of squares");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (DIMS_W'(idx_r) < used_r))
    else $error("divide index beyond used components");

  a_root_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT))
    else $error("square root finished outside its phase");

endmodule

`default_nettype wire
